FILE: hdl/hash_table_insert_remove_find_unit_macros.svh
// Assertion macros for the hash table unit.
// Used by the top level and the bucket modulo unit; depends on nothing.
`ifndef HASH_TABLE_INSERT_REMOVE_FIND_UNIT_MACROS_SVH
`define HASH_TABLE_INSERT_REMOVE_FIND_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define HT_ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define HT_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/htirf_pkg.sv
// Package for the hash table unit: sizes, codes, slot record and state type.
// Depends on nothing; used by every module of the unit.
package htirf_pkg;

   localparam int Buckets    = 256;
   localparam int Ways       = 4;
   localparam int BucketBits = (Buckets > 1) ? $clog2(Buckets) : 1;
   localparam int WayBits    = (Ways > 1) ? $clog2(Ways) : 1;
   localparam int KeyBits    = 31;
   localparam int ValueBits  = 32;
   localparam int CountBits  = 9;
   localparam int StepBits   = $clog2(KeyBits + 1);

   localparam logic [1:0] CmdInsert = 2'd0;
   localparam logic [1:0] CmdRemove = 2'd1;
   localparam logic [1:0] CmdFind   = 2'd2;
   localparam logic [1:0] CmdUnused = 2'd3;

   localparam logic [2:0] StInserted = 3'd0;
   localparam logic [2:0] StReplaced = 3'd1;
   localparam logic [2:0] StRemoved  = 3'd2;
   localparam logic [2:0] StFound    = 3'd3;
   localparam logic [2:0] StNotFound = 3'd4;
   localparam logic [2:0] StFull     = 3'd5;

   typedef struct packed {
      logic                        valid;
      logic [KeyBits-1:0]          key;
      logic signed [ValueBits-1:0] value;
   } slot_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HASH,
      S_READ,
      S_UPDATE
   } state_type;

endpackage

FILE: hdl/hash_table_insert_remove_find_unit.sv
// Hash table unit: each accepted item runs a bit-serial modulo of its key, one key bit a cycle,
// to pick the bucket; the S_READ state then reads the bucket row and S_UPDATE writes it
// back and registers the result. One item is in work at a time; the next is accepted
// once the unit is back in S_IDLE, unless a pending result is held by rsp_stall.
// Synchronous reset sets the bucket count to 256 and starts a pass that empties every bucket
// row, one a cycle, stalling requests until it ends. Needs htirf_pkg, modulo, RAM, macros.
`include "hash_table_insert_remove_find_unit_macros.svh"
module hash_table_insert_remove_find_unit
   import htirf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_command,
   input  logic [KeyBits-1:0]          req_key,
   input  logic signed [ValueBits-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic signed [ValueBits-1:0] rsp_found_value,
   input  logic                        csr_write,
   input  logic [CountBits-1:0]        csr_data
);

   state_type state_ff, state_in;

   logic [CountBits-1:0]        count_ff;
   logic [CountBits-1:0]        divisor;
   logic [1:0]                  cmd_ff;
   logic [KeyBits-1:0]          key_ff;
   logic signed [ValueBits-1:0] value_ff;
   logic [BucketBits-1:0]       bucket_ff;
   logic                        rsp_valid_ff;
   logic [2:0]                  status_ff, status_in;
   logic signed [ValueBits-1:0] found_ff, found_in;

   logic                  accept;
   logic                  ram_ready;
   logic                  mod_start, mod_done;
   logic [BucketBits-1:0] mod_rem;
   logic                  rd_en, wr_en;
   slot_type              rd_data [Ways];
   slot_type              wr_data [Ways];
   logic                  hit, has_free;
   logic [WayBits-1:0]    hit_way, free_way;

   // The saturated divisor; a count of zero acts as one bucket.
   always_comb begin
      if (count_ff == '0) begin
         divisor = CountBits'(1);
      end else if (count_ff > CountBits'(Buckets)) begin
         divisor = CountBits'(Buckets);
      end else begin
         divisor = count_ff;
      end
   end

   // Items are held off while the store is being cleared, while an item is in work, or while a result is held.
   assign accept    = req_valid && !req_stall;
   assign req_stall = !ram_ready || (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign mod_start = accept;

   htirf_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_key),
      .divisor   (divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rd_en = (state_ff == S_READ);

   htirf_bucket_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ready   (ram_ready),
      .rd_en   (rd_en),
      .rd_addr (bucket_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (bucket_ff),
      .wr_data (wr_data)
   );

   // Search the bucket in slot order for the key and for the lowest free slot.
   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      has_free = 1'b0;
      free_way = '0;
      for (int w = Ways - 1; w >= 0; w--) begin
         if (rd_data[w].valid && rd_data[w].key == key_ff) begin
            hit     = 1'b1;
            hit_way = WayBits'(w);
         end
         if (!rd_data[w].valid) begin
            has_free = 1'b1;
            free_way = WayBits'(w);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_HASH;
         S_HASH:   if (mod_done) state_in = S_READ;
         S_READ:   state_in = S_UPDATE;
         S_UPDATE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Row write-back and result for the update cycle.
   always_comb begin
      wr_en     = 1'b0;
      status_in = StNotFound;
      found_in  = '1;
      for (int w = 0; w < Ways; w++) begin
         wr_data[w] = rd_data[w];
      end
      if (state_ff == S_UPDATE) begin
         case (cmd_ff)
            CmdInsert: begin
               wr_en = 1'b1;
               if (hit) begin
                  wr_data[hit_way].value = value_ff;
                  status_in = StReplaced;
               end else if (has_free) begin
                  wr_data[free_way].valid = 1'b1;
                  wr_data[free_way].key   = key_ff;
                  wr_data[free_way].value = value_ff;
                  status_in = StInserted;
               end else begin
                  status_in = StFull;
               end
            end
            CmdRemove: begin
               if (hit) begin
                  wr_en = 1'b1;
                  wr_data[hit_way].valid = 1'b0;
                  status_in = StRemoved;
               end
            end
            CmdFind: begin
               if (hit) begin
                  status_in = StFound;
                  found_in  = rd_data[hit_way].value;
               end
            end
            default: status_in = StNotFound;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CountBits'(256);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            count_ff <= csr_data;
         end
         if (state_ff == S_UPDATE) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (mod_done) begin
         bucket_ff <= mod_rem;
      end
      if (state_ff == S_UPDATE) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;

   `HT_ASSERT_NEXT(a_update_gives_rsp, clock, reset, state_ff == S_UPDATE, rsp_valid_ff)
   `HT_ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != S_IDLE, req_stall)
   `HT_ASSERT_IMPLY(a_done_in_hash, clock, reset, mod_done, state_ff == S_HASH)
   `HT_ASSERT_IMPLY(a_write_in_update, clock, reset, wr_en, state_ff == S_UPDATE)

endmodule

FILE: hdl/htirf_modulo.sv
// Bit-serial restoring modulo of the key by the bucket count, one bit a cycle.
// Depends on htirf_pkg and the assertion macros header.
`include "hash_table_insert_remove_find_unit_macros.svh"
module htirf_modulo
   import htirf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [KeyBits-1:0]    dividend,
   input  logic [CountBits-1:0]  divisor,
   output logic                  done,
   output logic [BucketBits-1:0] remainder
);

   logic [KeyBits-1:0]   shift_ff, shift_in;
   logic [CountBits-1:0] rem_ff, rem_in;
   logic [StepBits-1:0]  count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic [CountBits:0]   trial;

   // Shift the next dividend bit in, subtract if the divisor fits.
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff, shift_ff[KeyBits-1]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         count_in = StepBits'(KeyBits);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[KeyBits-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = CountBits'(trial - {1'b0, divisor});
         end else begin
            rem_in = CountBits'(trial);
         end
         count_in = count_ff - 1'b1;
         if (count_ff == StepBits'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = busy_ff && (count_ff == StepBits'(1));
   assign remainder = BucketBits'(rem_in);

   `HT_ASSERT_NEXT(a_mod_runs, clock, reset, start, busy_ff)
   `HT_ASSERT_IMPLY(a_mod_count, clock, reset, busy_ff, count_ff != '0)
   `HT_ASSERT_IMPLY(a_mod_done_busy, clock, reset, done, busy_ff)

endmodule

FILE: hdl/htirf_bucket_ram.sv
// Bucket store: one row of Ways slots per bucket, one write and one read port.
// A clearing pass after reset writes every row empty; depends on htirf_pkg.
module htirf_bucket_ram
   import htirf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   output logic                  ready,
   input  logic                  rd_en,
   input  logic [BucketBits-1:0] rd_addr,
   output slot_type              rd_data [Ways],
   input  logic                  wr_en,
   input  logic [BucketBits-1:0] wr_addr,
   input  slot_type              wr_data [Ways]
);

   slot_type              mem [Buckets][Ways];
   slot_type              rdata_ff [Ways];
   logic                  clearing_ff, clearing_in;
   logic [BucketBits-1:0] clear_addr_ff, clear_addr_in;
   logic                  row_we;
   logic [BucketBits-1:0] row_addr;

   // After reset every row is written with empty slots, one row a cycle.
   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == BucketBits'(Buckets - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign row_we   = clearing_ff || wr_en;
   assign row_addr = clearing_ff ? clear_addr_ff : wr_addr;
   assign ready    = !clearing_ff;

   always_ff @(posedge clock) begin
      if (row_we) begin
         for (int w = 0; w < Ways; w++) begin
            if (clearing_ff) begin
               mem[row_addr][w] <= '0;
            end else begin
               mem[row_addr][w] <= wr_data[w];
            end
         end
      end
      if (rd_en) begin
         for (int w = 0; w < Ways; w++) begin
            rdata_ff[w] <= mem[rd_addr][w];
         end
      end
   end

   always_comb begin
      for (int w = 0; w < Ways; w++) begin
         rd_data[w] = rdata_ff[w];
      end
   end

endmodule
